// ----- sv/positional_list_engine_assert.svh -----
// Assertion macros shared by the list engine.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Checked on every edge outside reset.
`define PLE_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define PLE_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/ple_pkg.sv -----
`timescale 1ns / 1ps

package ple_pkg;

  localparam int CAPACITY    = 64;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int LEN_W       = 7;
  localparam int POS_W       = 7;
  localparam int DATA_W      = 32;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_ERASE   = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_READ    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // One classified request, as it travels from the front end to the back end.
  typedef struct packed {
    mode_t              op;
    status_t            status;
    logic [ADDR_W-1:0]  pos;
    logic [DATA_W-1:0]  value;
    logic [CNT_W-1:0]   n_before;
    logic [LEN_W-1:0]   length;
  } cmd_t;

  // Occupancy flags of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Length as reported: the element count taken modulo the field width.
  function automatic logic [LEN_W-1:0] len_field(input logic [CNT_W-1:0] c);
    logic [CMP_W-1:0] w;
    w = CMP_W'(c);
    return w[LEN_W-1:0];
  endfunction

  localparam logic [LEN_W-1:0] LEN_FULL = len_field(CNT_W'(CAPACITY));

endpackage

// ----- sv/ple_front.sv -----
`timescale 1ns / 1ps

module ple_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                mode,
  input  logic [6:0]                position,
  input  logic signed [31:0]        item_value,
  input  ple_pkg::qstat_t           q_stat,
  output logic                      push,
  output ple_pkg::cmd_t             cmd
);
  import ple_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  mode_t            op;
  status_t          st;

  // A transaction is taken whenever the queue has room.
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  assign op    = mode_t'(mode);
  assign pos_w = CMP_W'(position);
  assign cnt_w = CMP_W'(count);

  // Classify the request against the running element count.
  always_comb begin
    st         = ST_OK;
    count_next = count;
    unique case (op)
      MODE_INSERT: begin
        if (pos_w > cnt_w) begin
          st = ST_BAD_INDEX;
        end else if (count >= CNT_W'(CAPACITY)) begin
          st = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      MODE_ERASE: begin
        if (pos_w >= cnt_w) begin
          st = ST_BAD_INDEX;
        end else begin
          count_next = count - 1'b1;
        end
      end
      MODE_REVERSE: begin
        st = ST_OK;
      end
      MODE_READ: begin
        if (pos_w >= cnt_w) begin
          st = ST_BAD_INDEX;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // Command handed to the back end.
  always_comb begin
    cmd.op       = op;
    cmd.status   = st;
    cmd.pos      = position[ADDR_W-1:0];
    cmd.value    = item_value;
    cmd.n_before = count;
    cmd.length   = len_field(count_next);
  end

  // The count follows every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count_next;
    end
  end

endmodule

// ----- sv/ple_queue.sv -----
`timescale 1ns / 1ps

module ple_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ple_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output logic              head_valid,
  output ple_pkg::cmd_t     head_cmd,
  output ple_pkg::qstat_t   q_stat
);
  import ple_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);
  assign head_valid   = !q_stat.empty;
  assign head_cmd     = slots[rd_ptr];

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && head_valid;

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- sv/ple_back.sv -----
`timescale 1ns / 1ps

module ple_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  ple_pkg::cmd_t       head_cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [6:0]          list_length,
  output logic signed [31:0]  read_value
);
  import ple_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHIFT,
    S_TAIL,
    S_RV_LO,
    S_RV_HI,
    S_RV_WLO,
    S_RV_WHI,
    S_RD_ISSUE,
    S_RD_CAPT,
    S_DONE
  } state_t;

  state_t            state;
  cmd_t              cmd;
  logic [ADDR_W-1:0] src;
  logic [ADDR_W-1:0] pdest;
  logic [CNT_W-1:0]  remaining;
  logic              pend;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;
  logic [DATA_W-1:0] tmp;
  logic [DATA_W-1:0] res_read;
  status_t           out_status;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic              pop;
  logic [CNT_W-1:0]  m_ins;
  logic [CNT_W-1:0]  m_ers;
  logic [ADDR_W-1:0] lo_next;
  logic [ADDR_W-1:0] hi_next;

  assign cmd_ready = (state == S_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign status    = out_status;

  // Moves needed by an insert or an erase of the command at the queue head.
  assign m_ins = head_cmd.n_before - CNT_W'(head_cmd.pos);
  assign m_ers = head_cmd.n_before - CNT_W'(head_cmd.pos) - 1'b1;

  assign lo_next = lo + 1'b1;
  assign hi_next = hi - 1'b1;

  // Element memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Memory port control for each sequencer step.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = src;
    mem_wdata = rdata;
    mem_raddr = src;
    unique case (state)
      S_SHIFT: begin
        mem_we    = pend;
        mem_waddr = pdest;
      end
      S_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = cmd.pos;
        mem_wdata = cmd.value;
      end
      S_RV_LO: begin
        mem_raddr = lo;
      end
      S_RV_HI: begin
        mem_raddr = hi;
      end
      S_RV_WLO: begin
        mem_we    = 1'b1;
        mem_waddr = lo;
      end
      S_RV_WHI: begin
        mem_we    = 1'b1;
        mem_waddr = hi;
        mem_wdata = tmp;
      end
      S_RD_ISSUE: begin
        mem_raddr = cmd.pos;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A taken result clears the flag unless a new one is loaded below.
      if (out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cmd      <= head_cmd;
            res_read <= '0;
            pend     <= 1'b0;
            lo       <= '0;
            hi       <= ADDR_W'(head_cmd.n_before - 1'b1);
            if (head_cmd.status != ST_OK) begin
              state <= S_DONE;
            end else begin
              unique case (head_cmd.op)
                MODE_INSERT: begin
                  src       <= ADDR_W'(head_cmd.n_before - 1'b1);
                  remaining <= m_ins;
                  state     <= (m_ins == '0) ? S_TAIL : S_SHIFT;
                end
                MODE_ERASE: begin
                  src       <= head_cmd.pos + 1'b1;
                  remaining <= m_ers;
                  state     <= (m_ers == '0) ? S_DONE : S_SHIFT;
                end
                MODE_REVERSE: begin
                  state <= (head_cmd.n_before < CNT_W'(2)) ? S_DONE : S_RV_LO;
                end
                MODE_READ: begin
                  state <= S_RD_ISSUE;
                end
                default: begin
                  state <= S_DONE;
                end
              endcase
            end
          end
        end
        S_SHIFT: begin
          // Read one element ahead while the previous one is written back.
          if (remaining != '0) begin
            remaining <= remaining - 1'b1;
            pend      <= 1'b1;
            if (cmd.op == MODE_INSERT) begin
              src   <= src - 1'b1;
              pdest <= src + 1'b1;
            end else begin
              src   <= src + 1'b1;
              pdest <= src - 1'b1;
            end
          end else begin
            pend  <= 1'b0;
            state <= (cmd.op == MODE_INSERT) ? S_TAIL : S_DONE;
          end
        end
        S_TAIL: begin
          state <= S_DONE;
        end
        S_RV_LO: begin
          state <= S_RV_HI;
        end
        S_RV_HI: begin
          tmp   <= rdata;
          state <= S_RV_WLO;
        end
        S_RV_WLO: begin
          state <= S_RV_WHI;
        end
        S_RV_WHI: begin
          lo    <= lo_next;
          hi    <= hi_next;
          state <= (hi_next > lo_next) ? S_RV_LO : S_DONE;
        end
        S_RD_ISSUE: begin
          state <= S_RD_CAPT;
        end
        S_RD_CAPT: begin
          res_read <= rdata;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            out_status  <= cmd.status;
            list_length <= cmd.length;
            read_value  <= res_read;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/positional_list_engine.sv -----
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// request   in_valid / in_ready   mode, position, item_value
// result    out_valid / out_ready status, list_length, read_value
//
// Two-entry command queue between the front end and the memory sequencer.
// An insert moves the elements from its position up one place, then writes the
// item; an erase moves the later ones down; a reverse swaps pairs from both
// ends; rejected requests skip the memory. Reset is synchronous and
// clears the count, queue and result valid, not the memory. A waiting result
// holds the back end; the input stalls while the queue holds two commands.

`include "positional_list_engine_assert.svh"

module positional_list_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [6:0]         position,
  input  logic signed [31:0] item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [6:0]         list_length,
  output logic signed [31:0] read_value
);
  import ple_pkg::*;

  cmd_t   push_cmd;
  cmd_t   head_cmd;
  qstat_t q_stat;
  logic   push;
  logic   head_valid;
  logic   cmd_ready;

  // Request classification and element count.
  ple_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .position   (position),
    .item_value (item_value),
    .q_stat     (q_stat),
    .push       (push),
    .cmd        (push_cmd)
  );

  // Command queue between the two halves.
  ple_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (cmd_ready),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .q_stat     (q_stat)
  );

  // Memory sequencer and result register.
  ple_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (head_valid),
    .cmd_ready   (cmd_ready),
    .head_cmd    (head_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .list_length (list_length),
    .read_value  (read_value)
  );

  // A full status is only reported when the list is at capacity.
  `PLE_CHECK(a_full_len, out_valid && status == ST_FULL |-> list_length == LEN_FULL, "full below capacity")
  // A nonzero read value only comes with a successful transaction.
  `PLE_CHECK(a_read_ok, out_valid && read_value != 0 |-> status == ST_OK, "read value on a failure")
  // No result is offered right after reset.
  `PLE_CHECK_ALWAYS(a_rst_idle, rst |=> !out_valid, "result valid after reset")

endmodule
